>>> hdl/nrf_pkg.sv
`default_nettype none
package nrf_pkg;

  localparam int MaxFragmentLimitDefault = 4096;
  localparam int QueueDepth = 4;

  localparam logic [7:0] DollarByte  = 8'h24;
  localparam logic [7:0] RtpVerByte  = 8'h80;
  localparam logic [4:0] FuAType     = 5'd28;
  localparam logic [5:0] FuH265Type  = 6'd49;
  localparam logic [4:0] RtpHdrWords = 5'd16;
  localparam logic [15:0] RtpHdrLen  = 16'd12;

  // register indexes
  localparam logic [2:0] RegCodec   = 3'd0;
  localparam logic [2:0] RegPt      = 3'd1;
  localparam logic [2:0] RegSsrc    = 3'd2;
  localparam logic [2:0] RegChannel = 3'd3;
  localparam logic [2:0] RegMaxFrag = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_NAL, PH_PAYLOAD, PH_DROP
  } phase_t;

  typedef struct packed {
    logic        codec_mode;
    logic [6:0]  payload_type;
    logic [31:0] stream_ssrc;
    logic [7:0]  interleave_channel;
    logic [12:0] max_fragment;
  } cfg_t;

  // one accepted byte's work for the back end
  typedef struct packed {
    logic        err;
    logic        hdr;
    logic [7:0]  data_byte;
    logic [15:0] size;
    logic        marker;
    logic        pend;
    logic        fend;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [1:0]  hb;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [7:0]  h2;
  } job_t;

endpackage
`default_nettype wire

>>> hdl/nrf_front.sv
`default_nettype none
module nrf_front #(
  parameter int MAX_FRAGMENT_LIMIT = nrf_pkg::MaxFragmentLimitDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          frame_start,
  input  wire logic [21:0]   frame_length,
  input  wire logic [31:0]   frame_timestamp,
  input  wire nrf_pkg::cfg_t cfg,
  output logic               push,
  output nrf_pkg::job_t      job
);
  localparam int FW = $clog2(MAX_FRAGMENT_LIMIT + 1);

  nrf_pkg::phase_t phase, phase_next;
  logic [15:0] seq, seq_next;
  logic [21:0] bpos, bpos_next, rem, rem_next, lat_len, lat_len_next;
  logic [FW-1:0] fill, fill_next, lat_frag, lat_frag_next;
  logic [15:0] nal, nal_next;
  logic [31:0] ts, ts_next;
  logic lat_codec, lat_codec_next, frag, frag_next;

  logic [FW-1:0] clamp_frag, fill_inc;
  logic [21:0] hl, rem_dec;
  logic first, last, hdr_now;
  logic [21:0] pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= nrf_pkg::PH_IDLE;
      seq <= '0; bpos <= '0; rem <= '0; lat_len <= '0;
      fill <= '0; lat_frag <= '0; nal <= '0; ts <= '0;
      lat_codec <= 1'b0; frag <= 1'b0;
    end else if (take) begin
      phase <= phase_next;
      seq <= seq_next; bpos <= bpos_next; rem <= rem_next; lat_len <= lat_len_next;
      fill <= fill_next; lat_frag <= lat_frag_next; nal <= nal_next; ts <= ts_next;
      lat_codec <= lat_codec_next; frag <= frag_next;
    end
  end

  always_comb begin
    if ({19'd0, cfg.max_fragment} < 32'd16) clamp_frag = FW'(16);
    else if ({19'd0, cfg.max_fragment} > 32'(MAX_FRAGMENT_LIMIT))
      clamp_frag = FW'(MAX_FRAGMENT_LIMIT);
    else clamp_frag = FW'(cfg.max_fragment);
  end

  always_comb begin
    phase_next = phase;
    seq_next = seq; bpos_next = bpos; rem_next = rem; lat_len_next = lat_len;
    fill_next = fill; lat_frag_next = lat_frag; nal_next = nal; ts_next = ts;
    lat_codec_next = lat_codec; frag_next = frag;
    push = 1'b0;
    job = '0;
    hl = lat_codec ? 22'd6 : 22'd5;
    first = bpos == hl;
    last = {{(22 > FW ? 22 - FW : 0){1'b0}}, lat_frag} >= rem;
    pkt = last ? rem : 22'(lat_frag);
    hdr_now = fill == '0;
    fill_inc = fill + FW'(1);
    rem_dec = rem - 22'd1;

    if (frame_start) begin
      lat_codec_next = cfg.codec_mode;
      lat_frag_next = clamp_frag;
      lat_len_next = frame_length;
      ts_next = frame_timestamp;
      nal_next = '0; fill_next = '0; rem_next = '0; bpos_next = '0;
      if (frame_length <= (cfg.codec_mode ? 22'd6 : 22'd5) || data_byte != 8'h00) begin
        push = 1'b1; job.err = 1'b1; phase_next = nrf_pkg::PH_DROP;
      end else begin
        phase_next = nrf_pkg::PH_START; bpos_next = 22'd1;
      end
    end else begin
      unique case (phase)
        nrf_pkg::PH_START: begin
          if (data_byte != ((bpos == 22'd3) ? 8'h01 : 8'h00)) begin
            push = 1'b1; job.err = 1'b1; phase_next = nrf_pkg::PH_DROP;
          end else begin
            bpos_next = bpos + 22'd1;
            if (bpos_next >= 22'd4) phase_next = nrf_pkg::PH_NAL;
          end
        end
        nrf_pkg::PH_NAL: begin
          if (!lat_codec) begin
            if (data_byte == 8'h67 || data_byte == 8'h68 || data_byte == 8'h06 ||
                data_byte == 8'h65 || data_byte == 8'h61) begin
              nal_next = {8'h00, data_byte};
              bpos_next = bpos + 22'd1;
              rem_next = lat_len - 22'd5;
              frag_next = rem_next > 22'(lat_frag);
              fill_next = '0;
              phase_next = nrf_pkg::PH_PAYLOAD;
            end else begin
              push = 1'b1; job.err = 1'b1; phase_next = nrf_pkg::PH_DROP;
            end
          end else if (bpos == 22'd4) begin
            if (data_byte == 8'h40 || data_byte == 8'h42 || data_byte == 8'h44 ||
                data_byte == 8'h4e || data_byte == 8'h26 || data_byte == 8'h02) begin
              nal_next = {data_byte, 8'h00};
              bpos_next = bpos + 22'd1;
            end else begin
              push = 1'b1; job.err = 1'b1; phase_next = nrf_pkg::PH_DROP;
            end
          end else begin
            if (data_byte == 8'h01) begin
              nal_next = nal | 16'h0001;
              bpos_next = bpos + 22'd1;
              rem_next = lat_len - 22'd6;
              frag_next = rem_next > 22'(lat_frag);
              fill_next = '0;
              phase_next = nrf_pkg::PH_PAYLOAD;
            end else begin
              push = 1'b1; job.err = 1'b1; phase_next = nrf_pkg::PH_DROP;
            end
          end
        end
        nrf_pkg::PH_PAYLOAD: begin
          push = 1'b1;
          job.hdr = hdr_now;
          job.data_byte = data_byte;
          job.marker = last;
          job.seq = seq;
          job.ts = ts;
          if (!lat_codec) begin
            if (!frag) begin
              job.hb = 2'd1; job.h0 = nal[7:0];
            end else begin
              job.hb = 2'd2;
              job.h0 = {nal[7:5], nrf_pkg::FuAType};
              job.h1 = {first, last, 1'b0, nal[4:0]};
            end
          end else begin
            if (!frag) begin
              job.hb = 2'd2; job.h0 = nal[15:8]; job.h1 = nal[7:0];
            end else begin
              job.hb = 2'd3;
              job.h0 = {nal[15], nrf_pkg::FuH265Type, nal[8]};
              job.h1 = nal[7:0];
              job.h2 = {first, last, nal[14:9]};
            end
          end
          job.size = nrf_pkg::RtpHdrLen + {14'd0, job.hb} + pkt[15:0];
          if (hdr_now) seq_next = seq + 16'd1;
          rem_next = rem_dec;
          job.fend = rem_dec == '0;
          job.pend = job.fend || fill_inc >= lat_frag;
          fill_next = job.pend ? '0 : fill_inc;
          bpos_next = bpos + 22'd1;
          if (job.fend) phase_next = nrf_pkg::PH_IDLE;
        end
        nrf_pkg::PH_IDLE, nrf_pkg::PH_DROP: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/nrf_queue.sv
`default_nettype none
module nrf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire nrf_pkg::job_t wr_job,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output nrf_pkg::job_t      rd_job
);
  localparam int AW = $clog2(nrf_pkg::QueueDepth);

  nrf_pkg::job_t slots [nrf_pkg::QueueDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;

  assign full = count == (AW+1)'(nrf_pkg::QueueDepth);
  assign empty = count == '0;
  assign rd_job = slots[rp];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (push && !full) wp <= wp + AW'(1);
      if (pop && !empty) rp <= rp + AW'(1);
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

>>> hdl/nrf_back.sv
`default_nettype none
module nrf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          have,
  input  wire nrf_pkg::job_t job,
  input  wire nrf_pkg::cfg_t cfg,
  input  wire logic          out_ready,
  output logic               pop,
  output logic [7:0]         out_byte,
  output logic [3:0]         out_flags,
  output logic               out_last
);
  logic [4:0] idx;
  logic [4:0] last_idx;
  logic [4:0] hidx;
  logic word_last;

  assign last_idx = (job.hdr && !job.err) ? nrf_pkg::RtpHdrWords + {3'd0, job.hb} : 5'd0;
  assign word_last = idx == last_idx;
  assign pop = have && out_ready && word_last;
  assign out_last = word_last;
  assign hidx = idx - nrf_pkg::RtpHdrWords;

  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (have && out_ready) idx <= word_last ? 5'd0 : idx + 5'd1;
  end

  // flags: {frame_error, frame_last, packet_last, packet_first}
  always_comb begin
    out_byte = 8'h00;
    out_flags = 4'b0000;
    if (job.err) begin
      out_flags = 4'b1000;
    end else if (word_last) begin
      out_byte = job.data_byte;
      out_flags = {1'b0, job.fend, job.pend, 1'b0};
    end else begin
      unique case (idx)
        5'd0: begin
          out_byte = nrf_pkg::DollarByte; out_flags = 4'b0001;
        end
        5'd1: out_byte = cfg.interleave_channel;
        5'd2: out_byte = job.size[15:8];
        5'd3: out_byte = job.size[7:0];
        5'd4: out_byte = nrf_pkg::RtpVerByte;
        5'd5: out_byte = {job.marker, cfg.payload_type};
        5'd6: out_byte = job.seq[15:8];
        5'd7: out_byte = job.seq[7:0];
        5'd8: out_byte = job.ts[31:24];
        5'd9: out_byte = job.ts[23:16];
        5'd10: out_byte = job.ts[15:8];
        5'd11: out_byte = job.ts[7:0];
        5'd12: out_byte = cfg.stream_ssrc[31:24];
        5'd13: out_byte = cfg.stream_ssrc[23:16];
        5'd14: out_byte = cfg.stream_ssrc[15:8];
        5'd15: out_byte = cfg.stream_ssrc[7:0];
        default: begin
          if (hidx == 5'd0) out_byte = job.h0;
          else if (hidx == 5'd1) out_byte = job.h1;
          else out_byte = job.h2;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/nal_rtp_fragmenter_core.sv
`default_nettype none
// Channel  | Group                   | Contents
// input    | s_tvalid/s_tready       | tdata: data_byte, frame_length, timestamp; tuser: frame_start
// output   | m_tvalid/m_tready       | tdata: out_byte; tuser: pkt first/last, frame last, error
// config   | APB psel/penable/pwrite | codec, payload type, SSRC, channel, max fragment
//
// One input word is taken per cycle while the job queue has room.
// Each payload byte that opens a packet expands to 18-20 output words
// (interleave + RTP + NAL/FU headers, then the byte); the back end sends one
// word per cycle while m_tready is high; output words, not input bytes, set long-run rate.
// The four-entry job queue lets the front keep parsing while the back stalls.
// Reset (rst, synchronous) empties the queue and returns parsing to idle.
module nal_rtp_fragmenter_core #(
  parameter int MAX_FRAGMENT_LIMIT = nrf_pkg::MaxFragmentLimitDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // [7:0] data_byte, [29:8] frame_length, [61:30] timestamp
  input  wire logic [0:0]  s_tuser,  // [0] frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // [7:0] out_byte
  output logic [3:0]       m_tuser,  // [0] pkt first, [1] pkt last, [2] frame last, [3] error
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  nrf_pkg::cfg_t cfg;
  nrf_pkg::job_t wr_job, rd_job;
  logic push, full, empty, pop, take;

  assign pready = 1'b1;
  assign s_tready = !full;
  assign take = s_tvalid && s_tready;

  // config registers, word at byte address 4*index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.codec_mode <= 1'b0;
      cfg.payload_type <= 7'd96;
      cfg.stream_ssrc <= 32'd10;
      cfg.interleave_channel <= 8'd0;
      cfg.max_fragment <= 13'd1400;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        nrf_pkg::RegCodec:   cfg.codec_mode <= pwdata[0];
        nrf_pkg::RegPt:      cfg.payload_type <= pwdata[6:0];
        nrf_pkg::RegSsrc:    cfg.stream_ssrc <= pwdata;
        nrf_pkg::RegChannel: cfg.interleave_channel <= pwdata[7:0];
        nrf_pkg::RegMaxFrag: cfg.max_fragment <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      nrf_pkg::RegCodec:   prdata = {31'd0, cfg.codec_mode};
      nrf_pkg::RegPt:      prdata = {25'd0, cfg.payload_type};
      nrf_pkg::RegSsrc:    prdata = cfg.stream_ssrc;
      nrf_pkg::RegChannel: prdata = {24'd0, cfg.interleave_channel};
      nrf_pkg::RegMaxFrag: prdata = {19'd0, cfg.max_fragment};
      default:             prdata = 32'd0;
    endcase
  end

  nrf_front #(.MAX_FRAGMENT_LIMIT(MAX_FRAGMENT_LIMIT)) u_front (
    .clk, .rst, .take,
    .data_byte(s_tdata[7:0]),
    .frame_start(s_tuser[0]),
    .frame_length(s_tdata[29:8]),
    .frame_timestamp(s_tdata[61:30]),
    .cfg,
    .push,
    .job(wr_job)
  );

  nrf_queue u_queue (
    .clk, .rst,
    .push(push && take),
    .wr_job,
    .pop,
    .full, .empty,
    .rd_job
  );

  assign m_tvalid = !empty;

  nrf_back u_back (
    .clk, .rst,
    .have(!empty),
    .job(rd_job),
    .cfg,
    .out_ready(m_tready),
    .pop,
    .out_byte(m_tdata),
    .out_flags(m_tuser),
    .out_last(m_tlast)
  );

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tdata == 8'h00 && m_tlast)
    else $error("error word carries data or is not last");
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tlast && !m_tuser[1])
    else $error("packet start word closes its run");
  a_frame_end_pkt_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1] && m_tlast)
    else $error("frame end without packet end");
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid && s_tready)
    else $error("queue not empty after reset");

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int FragLimit = nrf_pkg::MaxFragmentLimitDefault;
  localparam int IdleLimit = 6000;

  typedef struct {
    logic [7:0] out_byte;
    logic       pkt_first;
    logic       pkt_last;
    logic       frame_last;
    logic       frame_error;
    logic       run_last;
  } packet_word_t;

  typedef enum int {
    FLT_NONE, FLT_SHORT, FLT_START, FLT_NAL1, FLT_NAL2, FLT_TRUNC
  } frame_fault_t;

  // Packetizer prediction: tracks the parser and queues the expected packet words.
  class packet_scoreboard;
    nrf_pkg::cfg_t   cfg;
    packet_word_t    exp_q[$];
    logic [15:0]     seq;
    logic [21:0]     pos;
    logic [12:0]     fill;
    logic [21:0]     remain;
    logic [15:0]     nal_hold;
    logic [31:0]     ts;
    nrf_pkg::phase_t phase;
    logic            codec_l;
    logic [12:0]     frag_l;
    logic [21:0]     len_l;
    logic            fragmented;
    int              fails;
    int              words_seen;
    int              errors_seen;

    function new();
      cfg.codec_mode = 1'b0;
      cfg.payload_type = 7'd96;
      cfg.stream_ssrc = 32'd10;
      cfg.interleave_channel = 8'd0;
      cfg.max_fragment = 13'd1400;
      seq = '0; pos = '0; fill = '0; remain = '0; nal_hold = '0; ts = '0;
      phase = nrf_pkg::PH_IDLE; codec_l = 1'b0; frag_l = '0; len_l = '0; fragmented = 1'b0;
      fails = 0; words_seen = 0; errors_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        nrf_pkg::RegCodec:   cfg.codec_mode = val[0];
        nrf_pkg::RegPt:      cfg.payload_type = val[6:0];
        nrf_pkg::RegSsrc:    cfg.stream_ssrc = val;
        nrf_pkg::RegChannel: cfg.interleave_channel = val[7:0];
        nrf_pkg::RegMaxFrag: cfg.max_fragment = val[12:0];
        default: ;
      endcase
    endfunction

    function void push(logic [7:0] b, logic pf, logic pl, logic fl, logic er);
      packet_word_t w;
      w.out_byte = b; w.pkt_first = pf; w.pkt_last = pl;
      w.frame_last = fl; w.frame_error = er; w.run_last = 1'b0;
      exp_q.push_back(w);
    endfunction

    function void drop_frame();
      push(8'h00, 0, 0, 0, 1);
      phase = nrf_pkg::PH_DROP;
    endfunction

    function void push_headers(logic [21:0] pkt, logic first, logic last);
      logic [7:0]  hdr [3];
      int          hb;
      logic [15:0] size;
      logic [15:0] p;
      if (!codec_l) begin
        if (!fragmented) begin
          hdr[0] = nal_hold[7:0]; hb = 1;
        end else begin
          hdr[0] = {nal_hold[7:5], nrf_pkg::FuAType};
          hdr[1] = {first, last, 1'b0, nal_hold[4:0]};
          hb = 2;
        end
      end else begin
        if (!fragmented) begin
          hdr[0] = nal_hold[15:8]; hdr[1] = nal_hold[7:0]; hb = 2;
        end else begin
          p = (nal_hold & ~16'h7e00) | {1'b0, nrf_pkg::FuH265Type, 9'd0};
          hdr[0] = p[15:8]; hdr[1] = p[7:0];
          hdr[2] = {first, last, nal_hold[14:9]};
          hb = 3;
        end
      end
      size = nrf_pkg::RtpHdrLen + 16'(hb) + pkt[15:0];
      push(nrf_pkg::DollarByte, 1, 0, 0, 0);
      push(cfg.interleave_channel, 0, 0, 0, 0);
      push(size[15:8], 0, 0, 0, 0);
      push(size[7:0], 0, 0, 0, 0);
      push(nrf_pkg::RtpVerByte, 0, 0, 0, 0);
      push({last, cfg.payload_type}, 0, 0, 0, 0);
      push(seq[15:8], 0, 0, 0, 0);
      push(seq[7:0], 0, 0, 0, 0);
      for (int i = 0; i < 4; i++) push(ts[31-8*i -: 8], 0, 0, 0, 0);
      for (int i = 0; i < 4; i++) push(cfg.stream_ssrc[31-8*i -: 8], 0, 0, 0, 0);
      for (int i = 0; i < hb; i++) push(hdr[i], 0, 0, 0, 0);
      seq = seq + 16'd1;
    endfunction

    function void start_payload(int hl);
      remain = len_l - 22'(hl);
      fragmented = remain > 22'(frag_l);
      fill = '0;
      phase = nrf_pkg::PH_PAYLOAD;
    endfunction

    // one accepted input word
    function void note_input(logic [7:0] b, logic fs, logic [21:0] len, logic [31:0] t);
      int   n0;
      int   hl;
      logic last;
      logic pend;
      logic fend;
      n0 = exp_q.size();
      if (fs) begin
        codec_l = cfg.codec_mode;
        if (cfg.max_fragment < 16) frag_l = 13'd16;
        else if (cfg.max_fragment > FragLimit) frag_l = 13'(FragLimit);
        else frag_l = cfg.max_fragment;
        len_l = len; ts = t;
        nal_hold = '0; fill = '0; remain = '0; pos = '0;
        hl = codec_l ? 6 : 5;
        if (len <= 22'(hl) || b != 8'h00) drop_frame();
        else begin
          phase = nrf_pkg::PH_START; pos = 22'd1;
        end
      end else if (phase == nrf_pkg::PH_START) begin
        if (b != ((pos == 3) ? 8'h01 : 8'h00)) drop_frame();
        else begin
          pos++;
          if (pos >= 4) phase = nrf_pkg::PH_NAL;
        end
      end else if (phase == nrf_pkg::PH_NAL) begin
        if (!codec_l) begin
          if (b inside {8'h67, 8'h68, 8'h06, 8'h65, 8'h61}) begin
            nal_hold = {8'h00, b}; pos++; start_payload(5);
          end else drop_frame();
        end else if (pos == 4) begin
          if (b inside {8'h40, 8'h42, 8'h44, 8'h4e, 8'h26, 8'h02}) begin
            nal_hold = {b, 8'h00}; pos++;
          end else drop_frame();
        end else begin
          if (b == 8'h01) begin
            nal_hold[0] = 1'b1; pos++; start_payload(6);
          end else drop_frame();
        end
      end else if (phase == nrf_pkg::PH_PAYLOAD) begin
        if (fill == 0) begin
          hl = codec_l ? 6 : 5;
          last = remain <= 22'(frag_l);
          push_headers(last ? remain : 22'(frag_l), pos == 22'(hl), last);
        end
        fill++;
        remain = remain - 22'd1;
        fend = remain == 0;
        pend = fend || fill >= frag_l;
        push(b, 0, pend, fend, 0);
        if (pend) fill = '0;
        pos = pos + 22'd1;
        if (fend) phase = nrf_pkg::PH_IDLE;
      end
      if (exp_q.size() > n0) exp_q[exp_q.size()-1].run_last = 1'b1;
    endfunction

    function void check_output(logic [7:0] b, logic [3:0] flags, logic tl);
      packet_word_t e;
      words_seen++;
      if (flags[3]) errors_seen++;
      if (exp_q.size() == 0) begin
        $error("unexpected word: byte %02h flags %b last %b", b, flags, tl);
        fails++;
        return;
      end
      e = exp_q.pop_front();
      if (b !== e.out_byte) begin
        $error("out_byte: expected %02h, got %02h", e.out_byte, b); fails++;
      end
      if (flags[0] !== e.pkt_first) begin
        $error("packet_first: expected %b, got %b", e.pkt_first, flags[0]); fails++;
      end
      if (flags[1] !== e.pkt_last) begin
        $error("packet_last: expected %b, got %b", e.pkt_last, flags[1]); fails++;
      end
      if (flags[2] !== e.frame_last) begin
        $error("frame_last: expected %b, got %b", e.frame_last, flags[2]); fails++;
      end
      if (flags[3] !== e.frame_error) begin
        $error("frame_error: expected %b, got %b", e.frame_error, flags[3]); fails++;
      end
      if (tl !== e.run_last) begin
        $error("run_last: expected %b, got %b", e.run_last, tl); fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  packet_scoreboard sb;
  bit  quiet;          // no idling on either side in the closing stretch
  int  sent_words;
  int  frames_sent;
  int  idle_cycles;
  int  stall_left;
  logic cur_codec;

  nal_rtp_fragmenter_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: random stall bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 12) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser, m_tlast);
  end

  // Watchdog: cycles with no handshake on any port.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("[nal_rtp_fragmenter_core] ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Entered and left at a falling edge.
  task automatic send_word(logic [7:0] b, logic fs, logic [21:0] len, logic [31:0] t);
    if (!quiet && $urandom_range(0, 10) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {2'b00, t, len, b};
    s_tuser = fs;
    do @(posedge clk); while (!s_tready);
    sb.note_input(b, fs, len, t);
    sent_words++;
    @(negedge clk);
  endtask

  task automatic idle_source();
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
  endtask

  // Let the block drain before touching registers; queued bytes may still be in flight.
  task automatic drain();
    idle_source();
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic write_all(logic codec, logic [6:0] pt, logic [31:0] ssrc, logic [7:0] ch,
                           logic [12:0] mf);
    reg_write(nrf_pkg::RegCodec, {31'd0, codec});
    reg_write(nrf_pkg::RegPt, {25'd0, pt});
    reg_write(nrf_pkg::RegSsrc, ssrc);
    reg_write(nrf_pkg::RegChannel, {24'd0, ch});
    reg_write(nrf_pkg::RegMaxFrag, {19'd0, mf});
    cur_codec = codec;
  endtask

  function automatic logic [7:0] good_nal(logic codec);
    logic [7:0] h264 [5] = '{8'h67, 8'h68, 8'h06, 8'h65, 8'h61};
    logic [7:0] h265 [6] = '{8'h40, 8'h42, 8'h44, 8'h4e, 8'h26, 8'h02};
    return codec ? h265[$urandom_range(0, 5)] : h264[$urandom_range(0, 4)];
  endfunction

  function automatic logic [7:0] bad_nal(logic codec);
    logic [7:0] b;
    do b = $urandom_range(0, 255);
    while (codec ? (b inside {8'h40, 8'h42, 8'h44, 8'h4e, 8'h26, 8'h02})
                 : (b inside {8'h67, 8'h68, 8'h06, 8'h65, 8'h61}));
    return b;
  endfunction

  // One access unit under the current codec; a fault breaks it at a chosen point.
  task automatic send_frame(int paylen, frame_fault_t fault);
    logic [7:0]  bytes [$];
    logic [21:0] len;
    logic [31:0] t;
    logic [7:0]  w;
    int          hl;
    int          p;
    hl = cur_codec ? 6 : 5;
    t = $urandom();
    bytes = '{8'h00, 8'h00, 8'h00, 8'h01, good_nal(cur_codec)};
    if (cur_codec) bytes.push_back(8'h01);
    for (int i = 0; i < paylen; i++) bytes.push_back($urandom_range(0, 255));
    len = 22'(hl + paylen);
    case (fault)
      FLT_SHORT: len = $urandom_range(0, hl);
      FLT_START: begin
        p = $urandom_range(0, 3);
        do w = $urandom_range(0, 255); while (w == ((p == 3) ? 8'h01 : 8'h00));
        bytes[p] = w;
      end
      FLT_NAL1: bytes[4] = bad_nal(cur_codec);
      FLT_NAL2: begin
        if (cur_codec) begin
          do w = $urandom_range(0, 255); while (w == 8'h01);
          bytes[5] = w;
        end else bytes[4] = bad_nal(1'b0);
      end
      FLT_TRUNC: begin
        // claimed length far beyond what is sent; the next frame start cuts it off
        len = $urandom_range(22'h200000, 22'h3fffff);
      end
      default: ;
    endcase
    frames_sent++;
    foreach (bytes[i]) send_word(bytes[i], i == 0, len, t);
  endtask

  task automatic send_stray(int count);
    for (int i = 0; i < count; i++)
      send_word($urandom_range(0, 255), 1'b0, $urandom(), $urandom());
  endtask

  task automatic random_frame();
    int           r;
    int           frag;
    frame_fault_t f;
    frag = (sb.cfg.max_fragment < 16) ? 16 : sb.cfg.max_fragment;
    r = $urandom_range(0, 99);
    if (r < 75) f = FLT_NONE;
    else if (r < 80) f = FLT_SHORT;
    else if (r < 85) f = FLT_START;
    else if (r < 90) f = FLT_NAL1;
    else if (r < 94) f = FLT_NAL2;
    else f = FLT_TRUNC;
    if ($urandom_range(0, 3) == 0) send_frame($urandom_range(1, 8), f);
    else send_frame($urandom_range(1, (frag > 16 ? 16 : frag) + 8), f);
    if ($urandom_range(0, 7) == 0) send_stray($urandom_range(1, 3));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    m_tready = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    quiet = 1'b0; sent_words = 0; frames_sent = 0; idle_cycles = 0; stall_left = 0;
    cur_codec = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, single-NAL H.264, stray bytes, short, start-code, NAL-type and truncation errors.
    send_stray(2);
    send_frame(3, FLT_NONE);
    send_frame(0, FLT_SHORT);
    send_frame(2, FLT_START);
    send_frame(2, FLT_NAL1);
    send_frame(4, FLT_TRUNC);
    send_frame(1, FLT_NONE);   // frame start mid-frame restarts
    drain();

    // Smallest fragment (0 clamps to 16): FU-A split one byte past the boundary.
    write_all(1'b0, 7'd0, 32'h0, 8'h00, 13'd0);
    send_frame(17, FLT_NONE);
    drain();

    // H.265 at the top extremes; 8191 clamps to the limit.
    write_all(1'b1, 7'd127, 32'hffff_ffff, 8'hff, 13'h1fff);
    send_frame(5, FLT_NONE);
    send_frame(3, FLT_NAL2);
    drain();

    // Random phases; the last one runs without idling.
    for (int ph = 0; ph < 2; ph++) begin
      int target;
      logic [12:0] mf;
      case ($urandom_range(0, 5))
        0: mf = $urandom_range(0, 15);
        1: mf = 13'(FragLimit);
        default: mf = $urandom_range(16, 48);
      endcase
      write_all($urandom_range(0, 1), $urandom_range(0, 127), $urandom(),
                $urandom_range(0, 255), mf);
      quiet = (ph == 1);
      target = sent_words + 10;
      while (sent_words < target) random_frame();
      drain();
    end

    $display("covered %0d frames, %0d input words, %0d output words (%0d frame errors)",
             frames_sent, sent_words, sb.words_seen, sb.errors_seen);
    $display("both codecs, single NAL and FU packets, fragment clamping, register extremes");
    if (sb.fails == 0 && sb.exp_q.size() == 0)
      $display("[nal_rtp_fragmenter_core] OK");
    else
      $display("[nal_rtp_fragmenter_core] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/nrf_pkg.sv
hdl/nrf_front.sv
hdl/nrf_queue.sv
hdl/nrf_back.sv
hdl/nal_rtp_fragmenter_core.sv
test/tb_top.sv
